[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/lfg_pkg.sv]
// ----------------------------------------------------------------------------
// lfg_pkg
// shared types and codes of the lagged fibonacci generator
// ----------------------------------------------------------------------------
`default_nettype none

package lfg_pkg;

  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LAG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LAG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHIFT = 2'd3;

  // item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_XOR = 2'd2
  } op_t;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [7:0] eff_l;
    logic [6:0] eff_k;
    logic [1:0] op;
    logic [4:0] shift;
    logic       lag_wr;
  } cfg_t;

  // control of the item waiting on ring read data
  typedef struct packed {
    logic is_load;
    logic err;
    logic fwd;
  } stage_t;

endpackage

`default_nettype wire

[hdl/lfg_in_if.sv]
// ----------------------------------------------------------------------------
// lfg_in_if
// input channel: load or step items
// ----------------------------------------------------------------------------
`default_nettype none

interface lfg_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seed_word;

  modport source (output valid, output action, output seed_word, input ready);
  modport sink   (input valid, input action, input seed_word, output ready);
endinterface

`default_nettype wire

[hdl/lfg_out_if.sv]
// ----------------------------------------------------------------------------
// lfg_out_if
// result channel: generated words
// ----------------------------------------------------------------------------
`default_nettype none

interface lfg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        not_seeded;

  modport source (output valid, output word, output not_seeded, input ready);
  modport sink   (input valid, input word, input not_seeded, output ready);
endinterface

`default_nettype wire

[hdl/lagged_fibonacci_generator_top.sv]
// ----------------------------------------------------------------------------
// lagged_fibonacci_generator_top
// lagged fibonacci generator over a ring of 32-bit words
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries load items (action 0, seed_word appended to the ring) and
//   step items (action 1, next word from r[i-k] op r[i-l]); out_ch carries
//   exactly one result per item, in order.
//   cfg_we/cfg_index/cfg_data write short_lag, long_lag, operation and
//   output_shift; write them only while no item is in flight. writing a lag
//   clears the seed count and the write position.
//   pipeline: an item passes the ring read stage, then its result sits in
//   the output register.
//   throughput: one item per cycle while out_ch.ready stays high, set by
//   the two ring read ports (one ram each) and the shared write port; a
//   near read that hits the word being written is forwarded.
//   stall: with out_ch.ready low one result waits in the output register and
//   one more item is held at the ring read stage, then in_ch.ready drops.
//   reset: all control state clears, lags return to 24 and 55; the ring
//   holds nothing usable, so long_lag loads are needed before a step is
//   answered with a real word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lagged_fibonacci_generator_top #(
  parameter int MAX_LAG = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lfg_in_if.sink                               in_ch,
  lfg_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [lfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lfg_pkg::*;

  localparam int AW = $clog2(MAX_LAG);

  cfg_t cfg;

  logic          in_xfer;
  logic          p_adv;
  logic          in_err;
  logic [8:0]    wp9, l9, k9, near9, wp_inc9;
  logic [AW-1:0] near_addr;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [7:0]    seed_cnt_r, seed_cnt_nxt;

  logic          p_valid_r, p_valid_nxt;
  stage_t        p_ctl_r, p_ctl_nxt;
  logic [31:0]   p_seed_r;
  logic [AW-1:0] p_addr_r;
  logic [31:0]   p_fwd_word_r;

  logic          o_valid_r, o_valid_nxt;
  logic [31:0]   o_word_r;
  logic          o_not_seeded_r;

  logic [31:0]   near_q, far_q;
  logic [31:0]   ram_wdata;
  logic          wr_req;
  logic          ram_we;
  logic [31:0]   res_word;
  logic          res_not_seeded;

  lfg_cfg #(.MAX_LAG(MAX_LAG)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  assign p_adv        = p_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready  = !p_valid_r || p_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_err       = (in_ch.action == ACT_STEP) && (seed_cnt_r < cfg.eff_l);

  // ring addresses
  assign wp9       = 9'(wp_r);
  assign l9        = {1'b0, cfg.eff_l};
  assign k9        = {2'b00, cfg.eff_k};
  assign near9     = (wp9 >= k9) ? (wp9 - k9) : (wp9 + l9 - k9);
  assign near_addr = AW'(near9);
  assign wp_inc9   = wp9 + 9'd1;

  always_comb begin
    wp_nxt       = wp_r;
    seed_cnt_nxt = seed_cnt_r;
    if (cfg.lag_wr) begin
      wp_nxt       = '0;
      seed_cnt_nxt = 8'd0;
    end else if (in_xfer && !in_err) begin
      wp_nxt = (wp_inc9 == l9) ? '0 : AW'(wp_inc9);
      if (in_ch.action == ACT_LOAD && seed_cnt_r < cfg.eff_l) begin
        seed_cnt_nxt = seed_cnt_r + 8'd1;
      end
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (in_xfer) begin
      p_valid_nxt = 1'b1;
    end else if (p_adv) begin
      p_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (p_adv) begin
      o_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  assign p_ctl_nxt.is_load = (in_ch.action == ACT_LOAD);
  assign p_ctl_nxt.err     = in_err;
  assign p_ctl_nxt.fwd     = ram_we && (near_addr == p_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      seed_cnt_r <= 8'd0;
      p_valid_r  <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      seed_cnt_r <= seed_cnt_nxt;
      p_valid_r  <= p_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_ctl_r      <= p_ctl_nxt;
      p_seed_r     <= in_ch.seed_word;
      p_addr_r     <= wp_r;
      p_fwd_word_r <= ram_wdata;
    end
    if (p_adv) begin
      o_word_r       <= res_word;
      o_not_seeded_r <= res_not_seeded;
    end
  end

  lfg_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LAG)) u_ram_near (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_addr_r),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (near_addr),
    .rdata (near_q)
  );

  lfg_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LAG)) u_ram_far (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_addr_r),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (wp_r),
    .rdata (far_q)
  );

  lfg_combine u_combine (
    .ctl        (p_ctl_r),
    .seed_word  (p_seed_r),
    .near_q     (near_q),
    .far_q      (far_q),
    .fwd_word   (p_fwd_word_r),
    .op         (cfg.op),
    .shift      (cfg.shift),
    .wdata      (ram_wdata),
    .wr_req     (wr_req),
    .word       (res_word),
    .not_seeded (res_not_seeded)
  );

  assign ram_we = p_adv && wr_req;

  assign out_ch.valid      = o_valid_r;
  assign out_ch.word       = o_word_r;
  assign out_ch.not_seeded = o_not_seeded_r;

  `ASSERT_ALWAYS(a_wp_in_ring, 9'(wp_r) < 9'(cfg.eff_l), "write position outside ring")
  `ASSERT_ALWAYS(a_seed_cnt_bound, seed_cnt_r <= cfg.eff_l, "seed count above long lag")
  `ASSERT_IMPLY(a_err_is_step, p_valid_r && p_ctl_r.err, !p_ctl_r.is_load, "unseeded load")
  `ASSERT_IMPLY(a_err_no_write, p_valid_r && p_ctl_r.err, !ram_we, "unseeded step wrote ring")

endmodule

`default_nettype wire

[hdl/lfg_ram.sv]
// ----------------------------------------------------------------------------
// lfg_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/lfg_cfg.sv]
// ----------------------------------------------------------------------------
// lfg_cfg
// configuration registers and clamping of the lags to their usable range
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_cfg #(
  parameter int MAX_LAG = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [lfg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lfg_pkg::cfg_t                         cfg_o
);

  import lfg_pkg::*;

  logic [6:0] short_r, short_nxt;
  logic [7:0] long_r, long_nxt;
  logic [1:0] op_r, op_nxt;
  logic [4:0] shift_r, shift_nxt;
  logic [7:0] eff_l;
  logic [6:0] eff_k;

  always_comb begin
    short_nxt = short_r;
    long_nxt  = long_r;
    op_nxt    = op_r;
    shift_nxt = shift_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT_LAG:    short_nxt = cfg_data[6:0];
        CFG_LONG_LAG:     long_nxt  = cfg_data;
        CFG_OPERATION:    op_nxt    = cfg_data[1:0];
        CFG_OUTPUT_SHIFT: shift_nxt = cfg_data[4:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= 7'd24;
      long_r  <= 8'd55;
      op_r    <= OP_ADD;
      shift_r <= 5'd0;
    end else begin
      short_r <= short_nxt;
      long_r  <= long_nxt;
      op_r    <= op_nxt;
      shift_r <= shift_nxt;
    end
  end

  always_comb begin
    eff_l = long_r;
    if (eff_l < 8'd2) begin
      eff_l = 8'd2;
    end
    if (int'(long_r) > MAX_LAG) begin
      eff_l = 8'(MAX_LAG);
    end
    eff_k = short_r;
    if (eff_k == 7'd0) begin
      eff_k = 7'd1;
    end
    if ({1'b0, eff_k} > eff_l - 8'd1) begin
      eff_k = 7'(eff_l - 8'd1);
    end
  end

  assign cfg_o.eff_l  = eff_l;
  assign cfg_o.eff_k  = eff_k;
  assign cfg_o.op     = op_r;
  assign cfg_o.shift  = shift_r;
  assign cfg_o.lag_wr = cfg_we && (cfg_index == CFG_SHORT_LAG || cfg_index == CFG_LONG_LAG);

endmodule

`default_nettype wire

[hdl/lfg_combine.sv]
// ----------------------------------------------------------------------------
// lfg_combine
// forms the new ring word and the emitted result of one item
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_combine (
  input  wire lfg_pkg::stage_t ctl,
  input  wire logic [31:0]  seed_word,
  input  wire logic [31:0]  near_q,
  input  wire logic [31:0]  far_q,
  input  wire logic [31:0]  fwd_word,
  input  wire logic [1:0]   op,
  input  wire logic [4:0]   shift,
  output logic      [31:0]  wdata,
  output logic              wr_req,
  output logic      [31:0]  word,
  output logic              not_seeded
);

  import lfg_pkg::*;

  logic [31:0] near_w;
  logic [31:0] gen_w;

  assign near_w = ctl.fwd ? fwd_word : near_q;

  always_comb begin
    case (op)
      OP_ADD:  gen_w = near_w + far_q;
      OP_SUB:  gen_w = near_w - far_q;
      default: gen_w = near_w ^ far_q;
    endcase
  end

  assign wdata      = ctl.is_load ? seed_word : gen_w;
  assign wr_req     = !ctl.err;
  assign word       = ctl.err ? 32'd0 : (wdata >> shift);
  assign not_seeded = ctl.err;

endmodule

`default_nettype wire
